### design/mbb_pkg.sv
// ----------------------------------------------------------------------------
// MSB-first bit buffer package
// Shared constants, operation codes, state type and the store request bundle.
// ----------------------------------------------------------------------------
package mbb_pkg;

    localparam int STORE_BYTES    = 4096;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int MAX_FIELD_BITS = 32;
    localparam int FIELD_W        = 32;
    localparam int COUNT_W        = 6;
    localparam int POS_W          = 16;
    localparam int CFG_W          = 13;
    localparam int FUNC_W         = 3;

    localparam logic [FUNC_W-1:0] FN_LOAD = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUT  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_GET  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SHOW = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SKIP = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SET  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_XFER,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

endpackage

### design/mbb_store.sv
// ----------------------------------------------------------------------------
// MSB-first bit buffer byte store
// Byte-wide memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mbb_store
    import mbb_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output logic [7:0] rdata
);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/msb_first_bit_buffer.sv
// ----------------------------------------------------------------------------
// MSB-first bit buffer
// Byte store with a bit position, read and written most significant bit
// first, one store byte per cycle.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                                    Transfer
//  command   in         start, busy, func, bit_count, bits_value,  start && !busy
//                       byte_address, byte_data, new_position
//  result    out        done, read_value, bit_position,            done
//                       bits_left, bytes_left, beyond_end
//  config    in         cfg_write, cfg_data                        cfg_write
//
//  A command is accepted in idle, checked in exec, moved one store byte at a
//  time in xfer by a put, get or show (up to five bytes), and finished in
//  final; the result shows the cycle after, with done high and busy already low.
//  The byte-wide read and write ports of the store set the per-byte cost.
//  Reset clears the position and the size register; the store is not cleared.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module msb_first_bit_buffer
    import mbb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [COUNT_W-1:0]  bit_count,
    input  logic [FIELD_W-1:0]  bits_value,
    input  logic [ADDR_W-1:0]   byte_address,
    input  logic [7:0]          byte_data,
    input  logic [POS_W-1:0]    new_position,
    input  logic                cfg_write,
    input  logic [CFG_W-1:0]    cfg_data,
    output logic                done,
    output logic [FIELD_W-1:0]  read_value,
    output logic [POS_W-1:0]    bit_position,
    output logic [POS_W-1:0]    bits_left,
    output logic [CFG_W-1:0]    bytes_left,
    output logic                beyond_end
);

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     position_reg, position_next;
    logic [CFG_W-1:0]     buffer_bytes_reg;
    logic                 done_reg, done_next;

    logic [FUNC_W-1:0]    func_reg;
    logic [COUNT_W-1:0]   n_reg;
    logic [FIELD_W-1:0]   val_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [7:0]           data_reg;
    logic [POS_W-1:0]     newpos_reg;

    logic [POS_W-1:0]     cur_pos_reg, cur_pos_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [FIELD_W-1:0]   acc_reg, acc_next;
    logic [FIELD_W-1:0]   put_sr_reg, put_sr_next;
    logic                 beyond_reg, beyond_next;

    logic [FIELD_W-1:0]   read_value_reg, read_value_next;
    logic [POS_W-1:0]     bit_position_reg, bit_position_next;
    logic [POS_W-1:0]     bits_left_reg, bits_left_next;
    logic [CFG_W-1:0]     bytes_left_reg, bytes_left_next;
    logic                 beyond_end_reg, beyond_end_next;

    logic [CFG_W-1:0]     used_bytes;
    logic [POS_W-1:0]     total_bits;
    logic [POS_W:0]       pos_plus_n;
    logic                 over;
    logic                 xfer_last;
    logic [2:0]           offset;
    logic [3:0]           room;
    logic [3:0]           k;
    logic [3:0]           sh;
    logic [7:0]           mask8;
    logic [7:0]           got;
    logic [7:0]           put_bits;
    logic [POS_W:0]       left_round;
    logic [7:0]           rdata;
    logic [COUNT_W-1:0]   n_clamped;
    store_req_t           req;

    assign used_bytes = (buffer_bytes_reg > CFG_W'(STORE_BYTES))
                        ? CFG_W'(STORE_BYTES) : buffer_bytes_reg;
    assign total_bits = {used_bytes, 3'b000};
    assign pos_plus_n = {1'b0, position_reg} + (POS_W + 1)'(n_reg);
    assign over       = pos_plus_n > {1'b0, total_bits};

    assign n_clamped = (bit_count > COUNT_W'(MAX_FIELD_BITS))
                       ? COUNT_W'(MAX_FIELD_BITS) : bit_count;

    assign offset    = cur_pos_reg[2:0];
    assign room      = 4'd8 - {1'b0, offset};
    assign k         = (rem_reg < COUNT_W'(room)) ? rem_reg[3:0] : room;
    assign sh        = room - k;
    assign mask8     = 8'hFF >> (4'd8 - k);
    assign got       = (rdata >> sh) & mask8;
    assign put_bits  = put_sr_reg[FIELD_W-1 -: 8] >> (4'd8 - k);
    assign xfer_last = (rem_reg == COUNT_W'(k));

    mbb_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((func_reg inside {FN_PUT, FN_GET, FN_SHOW}) && !over && n_reg != '0)
                begin
                    state_next = ST_XFER;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_XFER:
            begin
                if (xfer_last)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        position_next     = position_reg;
        done_next         = 1'b0;
        cur_pos_next      = cur_pos_reg;
        rem_next          = rem_reg;
        acc_next          = acc_reg;
        put_sr_next       = put_sr_reg;
        beyond_next       = beyond_reg;
        read_value_next   = read_value_reg;
        bit_position_next = bit_position_reg;
        bits_left_next    = bits_left_reg;
        bytes_left_next   = bytes_left_reg;
        beyond_end_next   = beyond_end_reg;
        left_round        = '0;
        req               = '0;
        case (state_reg)
            ST_EXEC:
            begin
                acc_next     = '0;
                beyond_next  = 1'b0;
                cur_pos_next = position_reg;
                rem_next     = n_reg;
                put_sr_next  = val_reg << (COUNT_W'(FIELD_W) - n_reg);
                req.re       = 1'b1;
                req.raddr    = position_reg[ADDR_W+2:3];
                case (func_reg)
                    FN_LOAD:
                    begin
                        if ({1'b0, addr_reg} >= used_bytes)
                        begin
                            beyond_next = 1'b1;
                        end
                        else
                        begin
                            req.we    = 1'b1;
                            req.waddr = addr_reg;
                            req.wdata = data_reg;
                        end
                    end
                    FN_PUT, FN_GET, FN_SHOW, FN_SKIP:
                    begin
                        if (over)
                        begin
                            beyond_next = 1'b1;
                        end
                        else if (func_reg != FN_SHOW)
                        begin
                            position_next = pos_plus_n[POS_W-1:0];
                        end
                    end
                    FN_SET:
                    begin
                        if (newpos_reg > total_bits)
                        begin
                            beyond_next = 1'b1;
                        end
                        else
                        begin
                            position_next = newpos_reg;
                        end
                    end
                    default:
                    begin
                        beyond_next = 1'b0;
                    end
                endcase
            end
            ST_XFER:
            begin
                cur_pos_next = cur_pos_reg + POS_W'(k);
                rem_next     = rem_reg - COUNT_W'(k);
                put_sr_next  = put_sr_reg << k;
                if (func_reg == FN_PUT)
                begin
                    req.we    = 1'b1;
                    req.waddr = cur_pos_reg[ADDR_W+2:3];
                    req.wdata = rdata | (put_bits << sh);
                end
                else
                begin
                    acc_next = (acc_reg << k) | FIELD_W'(got);
                end
                req.re    = !xfer_last;
                req.raddr = cur_pos_next[ADDR_W+2:3];
            end
            ST_FINAL:
            begin
                done_next         = 1'b1;
                read_value_next   = acc_reg;
                beyond_end_next   = beyond_reg;
                bit_position_next = position_reg;
                bits_left_next    = (position_reg < total_bits)
                                    ? (total_bits - position_reg) : '0;
                left_round        = {1'b0, bits_left_next} + (POS_W + 1)'(7);
                bytes_left_next   = left_round[CFG_W+2:3];
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            position_reg     <= '0;
            buffer_bytes_reg <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            position_reg <= position_next;
            done_reg     <= done_next;
            if (cfg_write)
            begin
                buffer_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            func_reg   <= func;
            n_reg      <= n_clamped;
            val_reg    <= bits_value;
            addr_reg   <= byte_address;
            data_reg   <= byte_data;
            newpos_reg <= new_position;
        end
        cur_pos_reg      <= cur_pos_next;
        rem_reg          <= rem_next;
        acc_reg          <= acc_next;
        put_sr_reg       <= put_sr_next;
        beyond_reg       <= beyond_next;
        read_value_reg   <= read_value_next;
        bit_position_reg <= bit_position_next;
        bits_left_reg    <= bits_left_next;
        bytes_left_reg   <= bytes_left_next;
        beyond_end_reg   <= beyond_end_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign read_value   = read_value_reg;
    assign bit_position = bit_position_reg;
    assign bits_left    = bits_left_reg;
    assign bytes_left   = bytes_left_reg;
    assign beyond_end   = beyond_end_reg;

    a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINAL))
        else $error("Result strobe without a finishing cycle.");

    a_refused_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && beyond_end) |-> (read_value == '0))
        else $error("Refused access returned a nonzero value.");

    a_busy_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("Command finished without a result.");

    a_xfer_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_XFER) |-> (rem_reg != '0))
        else $error("Byte transfer with no bits remaining.");

endmodule
